// ----- sv/glob_pattern_matcher_macros.svh -----
// ----------------------------------------------------------------------------
// glob_pattern_matcher_macros
// assertion macros for the glob pattern matcher, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GLOB_PATTERN_MATCHER_MACROS_SVH
`define GLOB_PATTERN_MATCHER_MACROS_SVH

`ifndef SYNTH

// condition in a cycle implies consequence in the same cycle
`define GPM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glob matcher check failed");

// condition in a cycle implies consequence in the next cycle
`define GPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glob matcher check failed");

`else

`define GPM_ASSERT_SAME(lbl, ante, cons)
`define GPM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/gpm_pkg.sv -----
// ----------------------------------------------------------------------------
// gpm_pkg
// shared constants and types of the glob pattern matcher
// ----------------------------------------------------------------------------
package gpm_pkg;

    // pattern store depth and derived widths
    localparam int TOKENS      = 32;
    localparam int POS         = TOKENS + 1;
    localparam int LEN_W       = $clog2(TOKENS + 1);
    localparam int CODE_W      = 16;
    localparam int SCAN_LEVELS = $clog2(POS);

    // special code points
    localparam logic [CODE_W-1:0] CH_NUL   = 16'h0000;
    localparam logic [CODE_W-1:0] CH_DOT   = 16'h002e;
    localparam logic [CODE_W-1:0] CH_SLASH = 16'h002f;

    // transaction operations
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_CHAR   = 2'd2,
        OP_END    = 2'd3
    } op_t;

    // token kinds
    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ANY     = 2'd1,
        KIND_STAR    = 2'd2,
        KIND_CLASS   = 2'd3
    } kind_t;

    // progress of the subject towards the names "." and ".."
    typedef enum logic [1:0] {
        DOT_NONE  = 2'd0,
        DOT_ONE   = 2'd1,
        DOT_TWO   = 2'd2,
        DOT_OTHER = 2'd3
    } dot_t;

    // token as held in one cell, class range already ordered
    typedef struct packed {
        kind_t             kind;
        logic [CODE_W-1:0] lo;
        logic [CODE_W-1:0] hi;
        logic              start;
        logic              inverted;
    } token_t;

    // per-cell status towards the chain logic
    typedef struct packed {
        logic live;
        logic cont;
        logic star;
        logic inverted;
        logic hit;
    } cell_stat_t;

endpackage

// ----- sv/gpm_cell.sv -----
// ----------------------------------------------------------------------------
// gpm_cell
// one pattern token: holds the token and tests the current subject code point
// ----------------------------------------------------------------------------
module gpm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          load,
    input  gpm_pkg::token_t               token,
    input  logic                          mark_live,
    input  logic [gpm_pkg::CODE_W-1:0]    code,
    output gpm_pkg::cell_stat_t           status
);
    import gpm_pkg::*;

    token_t tok_reg;
    logic   live_reg;
    logic   live_next;
    logic   raw_hit;

    // token storage, written once per append
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg <= token;
        end
    end

    // live marks a token inside the effective pattern
    always_comb
    begin
        live_next = live_reg;
        if (clear)
        begin
            live_next = 1'b0;
        end
        else if (load)
        begin
            live_next = mark_live;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    // token test against the subject code point
    always_comb
    begin
        case (tok_reg.kind)
            KIND_LITERAL: raw_hit = (tok_reg.lo == code);
            KIND_ANY:     raw_hit = 1'b1;
            KIND_STAR:    raw_hit = 1'b0;
            KIND_CLASS:   raw_hit = (tok_reg.lo <= code) && (code <= tok_reg.hi);
            default:      raw_hit = 1'b0;
        endcase
    end

    assign status.live     = live_reg;
    assign status.cont     = live_reg & ~tok_reg.start;
    assign status.star     = live_reg & (tok_reg.kind == KIND_STAR);
    assign status.inverted = live_reg & tok_reg.inverted;
    assign status.hit      = live_reg & raw_hit;

endmodule

// ----- sv/gpm_scan.sv -----
// ----------------------------------------------------------------------------
// gpm_scan
// segmented carry along the cell chain: chain[k] = seed[k] | pass[k] & chain[k-1]
// ----------------------------------------------------------------------------
module gpm_scan (
    input  logic [gpm_pkg::POS-1:0] seed,
    input  logic [gpm_pkg::POS-1:0] pass,
    output logic [gpm_pkg::POS-1:0] chain
);
    import gpm_pkg::*;

    logic [POS-1:0] lv_g [SCAN_LEVELS+1];
    logic [POS-1:0] lv_p [SCAN_LEVELS+1];

    // prefix tree, distance doubles at each level
    always_comb
    begin
        lv_g[0] = seed;
        lv_p[0] = pass;
        for (int l = 0; l < SCAN_LEVELS; l++)
        begin
            for (int k = 0; k < POS; k++)
            begin
                if (k >= (1 << l))
                begin
                    lv_g[l+1][k] = lv_g[l][k] | (lv_p[l][k] & lv_g[l][k - (1 << l)]);
                    lv_p[l+1][k] = lv_p[l][k] & lv_p[l][k - (1 << l)];
                end
                else
                begin
                    lv_g[l+1][k] = lv_g[l][k];
                    lv_p[l+1][k] = lv_p[l][k];
                end
            end
        end
    end

    assign chain = lv_g[SCAN_LEVELS];

endmodule

// ----- sv/glob_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// glob_pattern_matcher: every transaction runs an update of the position bits
// across the cell chain, then a star closure pass.
// An end-of-subject result is registered and shows in the cycle after acceptance.
// Reset (rst_n, asynchronous) empties the pattern; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "glob_pattern_matcher_macros.svh"

module glob_pattern_matcher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [1:0]                    operation,
    input  logic [1:0]                    token_kind,
    input  logic [gpm_pkg::CODE_W-1:0]    code_lo,
    input  logic [gpm_pkg::CODE_W-1:0]    code_hi,
    input  logic                          opens_class,
    input  logic                          complemented,
    input  logic [gpm_pkg::CODE_W-1:0]    subject_code,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          matched,
    output logic                          pattern_overflowed
);
    import gpm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CLOSE = 2'b10
    } state_t;

    state_t            state_reg;
    logic [POS-1:0]    active_reg;
    logic [POS-1:0]    pre_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              overflow_reg;
    logic              last_class_reg;
    logic              last_inv_reg;
    logic              cut_seen_reg;
    logic              dot_first_reg;
    dot_t              dot_reg;
    logic              result_valid_reg;
    logic              matched_reg;
    logic              overflowed_reg;

    op_t               op;
    kind_t             kind_in;
    logic              take;
    logic              room;
    logic              store;
    logic              clear_cells;
    logic              is_class;
    logic              is_cut;
    logic              tok_start;
    logic              tok_inv;
    token_t            new_token;

    cell_stat_t        stat [TOKENS];
    logic [TOKENS-1:0] live_v;
    logic [TOKENS-1:0] cont_v;
    logic [TOKENS-1:0] star_v;
    logic [TOKENS-1:0] inv_v;
    logic [TOKENS-1:0] hit_v;

    logic [POS-1:0]    grp_hit;
    logic [POS-1:0]    grp_act;
    logic [POS-1:0]    closed;
    logic [TOKENS-1:0] fire;
    logic [TOKENS-1:0] last;
    logic [POS-1:0]    nxt;
    logic [POS-1:0]    end_pos;
    logic              at_end;
    logic              dot_name;
    logic              match_now;

    assign op      = op_t'(operation);
    assign kind_in = kind_t'(token_kind);

    // handshake: one transaction at a time, result register may still be full
    assign item_ready = (state_reg == ST_IDLE) && (!result_valid_reg || result_ready);
    assign take       = item_valid && item_ready;

    // token preparation for an append
    assign room        = (length_reg < LEN_W'(TOKENS));
    assign store       = take && (op == OP_APPEND) && room;
    assign clear_cells = take && (op == OP_CLEAR);
    assign is_class    = (kind_in == KIND_CLASS);
    assign is_cut      = (kind_in == KIND_LITERAL)
                         && ((code_lo == CH_SLASH) || (code_lo == CH_NUL));
    assign tok_start   = !is_class || !last_class_reg || opens_class;
    assign tok_inv     = is_class && (tok_start ? complemented : last_inv_reg);

    always_comb
    begin
        new_token.kind     = kind_in;
        new_token.lo       = code_lo;
        new_token.hi       = code_hi;
        new_token.start    = tok_start;
        new_token.inverted = tok_inv;
        if (is_class && (code_hi < code_lo))
        begin
            new_token.lo = code_hi;
            new_token.hi = code_lo;
        end
    end

    // row of token cells
    for (genvar k = 0; k < TOKENS; k++)
    begin : g_cell
        gpm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (clear_cells),
            .load      (store && (length_reg == LEN_W'(k))),
            .token     (new_token),
            .mark_live (!cut_seen_reg && !is_cut),
            .code      (subject_code),
            .status    (stat[k])
        );
        assign live_v[k] = stat[k].live;
        assign cont_v[k] = stat[k].cont;
        assign star_v[k] = stat[k].star;
        assign inv_v[k]  = stat[k].inverted;
        assign hit_v[k]  = stat[k].hit;
    end

    // class groups: or of range hits and the opener's active bit along the group
    gpm_scan u_scan_hit (
        .seed  ({1'b0, hit_v}),
        .pass  ({1'b0, cont_v}),
        .chain (grp_hit)
    );

    gpm_scan u_scan_act (
        .seed  ({1'b0, active_reg[TOKENS-1:0]}),
        .pass  ({1'b0, cont_v}),
        .chain (grp_act)
    );

    // a group fires from its last cell into the next position
    assign fire = live_v & ~star_v & grp_act[TOKENS-1:0] & (inv_v ^ grp_hit[TOKENS-1:0]);
    assign last = live_v & ~{1'b0, cont_v[TOKENS-1:1]};
    assign nxt  = {1'b0, star_v & active_reg[TOKENS-1:0]} | {fire & last, 1'b0};

    // star closure: an active star also activates the position after it
    gpm_scan u_scan_close (
        .seed  (pre_reg),
        .pass  ({star_v, 1'b0}),
        .chain (closed)
    );

    // end position is the first cell outside the effective pattern
    assign end_pos   = ~{1'b0, live_v} & {live_v, 1'b1};
    assign at_end    = |(active_reg & end_pos);
    assign dot_name  = (dot_reg == DOT_ONE) || (dot_reg == DOT_TWO);
    assign match_now = !overflow_reg && at_end && !(dot_name && !dot_first_reg);

    // control and matcher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            active_reg       <= POS'(1);
            pre_reg          <= POS'(1);
            length_reg       <= '0;
            overflow_reg     <= 1'b0;
            last_class_reg   <= 1'b0;
            last_inv_reg     <= 1'b0;
            cut_seen_reg     <= 1'b0;
            dot_first_reg    <= 1'b0;
            dot_reg          <= DOT_NONE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // two-step sequencer: update, then closure
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        state_reg <= ST_CLOSE;
                        pre_reg   <= (op == OP_CHAR) ? nxt : POS'(1);
                    end
                end
                ST_CLOSE:
                begin
                    active_reg <= closed;
                    state_reg  <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // per-operation bookkeeping
            if (take)
            begin
                case (op)
                    OP_CLEAR:
                    begin
                        length_reg     <= '0;
                        overflow_reg   <= 1'b0;
                        last_class_reg <= 1'b0;
                        last_inv_reg   <= 1'b0;
                        cut_seen_reg   <= 1'b0;
                        dot_first_reg  <= 1'b0;
                        dot_reg        <= DOT_NONE;
                    end
                    OP_APPEND:
                    begin
                        if (room)
                        begin
                            length_reg     <= length_reg + LEN_W'(1);
                            last_class_reg <= is_class;
                            last_inv_reg   <= tok_inv;
                            cut_seen_reg   <= cut_seen_reg | is_cut;
                            if (length_reg == '0)
                            begin
                                dot_first_reg <= (kind_in == KIND_LITERAL)
                                                 && (code_lo == CH_DOT);
                            end
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                        dot_reg <= DOT_NONE;
                    end
                    OP_CHAR:
                    begin
                        if ((subject_code == CH_DOT) && (dot_reg == DOT_NONE))
                        begin
                            dot_reg <= DOT_ONE;
                        end
                        else if ((subject_code == CH_DOT) && (dot_reg == DOT_ONE))
                        begin
                            dot_reg <= DOT_TWO;
                        end
                        else
                        begin
                            dot_reg <= DOT_OTHER;
                        end
                    end
                    OP_END:
                    begin
                        dot_reg <= DOT_NONE;
                    end
                    default:
                    begin
                        dot_reg <= dot_reg;
                    end
                endcase
            end

            // result transaction register
            if (take && (op == OP_END))
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && (op == OP_END))
        begin
            matched_reg    <= match_now;
            overflowed_reg <= overflow_reg;
        end
    end

    assign result_valid       = result_valid_reg;
    assign matched            = matched_reg;
    assign pattern_overflowed = overflowed_reg;

    // checks
    `GPM_ASSERT_NEXT(a_close_one_cycle, state_reg == ST_CLOSE, state_reg == ST_IDLE)
    `GPM_ASSERT_NEXT(a_take_starts_close, take, state_reg == ST_CLOSE)
    `GPM_ASSERT_SAME(a_no_active_cont, state_reg == ST_IDLE, (active_reg[TOKENS-1:0] & cont_v) == '0)
    `GPM_ASSERT_SAME(a_overflow_no_match, result_valid_reg && overflowed_reg, !matched_reg)

endmodule
